@@ src/horner_polynomial_plus_one_macros.svh @@
// Assertion macros shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef HORNER_POLYNOMIAL_PLUS_ONE_MACROS_SVH
`define HORNER_POLYNOMIAL_PLUS_ONE_MACROS_SVH
`ifndef SYNTHESIS
`define HPP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hpp: same-cycle check failed");
`define HPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hpp: next-cycle check failed");
`else
`define HPP_ASSERT_SAME(lbl, ante, cons)
`define HPP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ src/hpp_pkg.sv @@
package hpp_pkg;

  localparam int HPP_MAX_TERMS = 7;
  localparam int COEF_REGS     = 7;

  localparam int X_W     = 24;
  localparam int COEF_W  = 24;
  localparam int ACC_W   = 32;
  localparam int CNT_W   = 3;
  localparam int FRAC_W  = 16;
  localparam int SUM_W   = ACC_W + 1;
  localparam int PROD_W  = SUM_W + X_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE  = 3'd1;

  localparam logic signed [ACC_W-1:0] ONE_Q16 = 32'sd65536;
  localparam logic signed [ACC_W-1:0] SAT_HI  = 32'sh7fff_ffff;
  localparam logic signed [ACC_W-1:0] SAT_LO  = 32'sh8000_0000;

  // Data moving from one Horner cell to the next.
  typedef struct packed {
    logic                     valid;
    logic                     sat;
    logic signed [ACC_W-1:0]  acc;
    logic signed [X_W-1:0]    x;
  } hpp_stage_t;

endpackage

@@ src/horner_polynomial_plus_one.sv @@
// Channel  | Direction | Handshake          | Payload
// in_      | input     | in_valid/in_stall  | in_sample_x
// out_     | output    | out_valid/out_stall| out_poly_value, out_saturated
// cfg_     | input     | cfg_wr_en          | cfg_index, cfg_data
//
// One sample is accepted per cycle while in_stall is low.
// Each Horner cell: add and multiply, register, then round and saturate.
// The last stage adds 1.0 and feeds the output register.
// A stalled output freezes the chain; in_stall = out_valid & out_stall.
// Synchronous reset clears all valid bits and the configuration registers.
module horner_polynomial_plus_one #(
  parameter int MAX_TERMS = hpp_pkg::HPP_MAX_TERMS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [hpp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hpp_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [hpp_pkg::X_W-1:0]        in_sample_x,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [hpp_pkg::ACC_W-1:0]      out_poly_value,
  output logic                                  out_saturated
);
  import hpp_pkg::*;
  `include "horner_polynomial_plus_one_macros.svh"

  logic [CNT_W-1:0]          term_count_r;
  logic signed [COEF_W-1:0]  coef_r [COEF_REGS];
  logic [CNT_W-1:0]          n_eff;
  logic                      advance;
  hpp_stage_t                chain [MAX_TERMS+1];

  logic signed [SUM_W-1:0]   fsum;
  logic                      out_valid_r;
  logic signed [ACC_W-1:0]   out_poly_value_r;
  logic                      out_saturated_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= '0;
      for (int i = 0; i < COEF_REGS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_TERM_COUNT) begin
        term_count_r <= cfg_data[CNT_W-1:0];
      end else begin
        coef_r[CFG_IDX_W'(cfg_index - CFG_COEF_BASE)] <= $signed(cfg_data[COEF_W-1:0]);
      end
    end
  end

  assign n_eff    = (term_count_r > CNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : term_count_r;
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  assign chain[0].valid = in_valid;
  assign chain[0].sat   = 1'b0;
  assign chain[0].acc   = '0;
  assign chain[0].x     = in_sample_x;

  // Cell k applies the coefficient of index MAX_TERMS-1-k; cells at or
  // above the term count pass the zero accumulator through untouched.
  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_cell
    hpp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (advance),
      .active    (CNT_W'(MAX_TERMS - 1 - k) < n_eff),
      .coef      (coef_r[MAX_TERMS - 1 - k]),
      .stage_in  (chain[k]),
      .stage_out (chain[k+1])
    );
  end

  assign fsum = SUM_W'(chain[MAX_TERMS].acc) + SUM_W'(ONE_Q16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= chain[MAX_TERMS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (fsum[SUM_W-1] != fsum[SUM_W-2]) begin
        out_poly_value_r <= fsum[SUM_W-1] ? SAT_LO : SAT_HI;
        out_saturated_r  <= 1'b1;
      end else begin
        out_poly_value_r <= $signed(fsum[ACC_W-1:0]);
        out_saturated_r  <= chain[MAX_TERMS].sat;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_poly_value = out_poly_value_r;
  assign out_saturated  = out_saturated_r;

  `HPP_ASSERT_NEXT(a_last_to_out, chain[MAX_TERMS].valid && advance, out_valid_r)
  `HPP_ASSERT_NEXT(a_chain_hold, !advance, $stable(chain[MAX_TERMS].acc) && $stable(chain[MAX_TERMS].valid))
  `HPP_ASSERT_NEXT(a_sat_kept, advance && chain[MAX_TERMS].valid && chain[MAX_TERMS].sat, out_saturated_r)

endmodule

@@ src/hpp_cell.sv @@
module hpp_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              active,
  input  logic signed [hpp_pkg::COEF_W-1:0] coef,
  input  hpp_pkg::hpp_stage_t               stage_in,
  output hpp_pkg::hpp_stage_t               stage_out
);
  import hpp_pkg::*;

  logic signed [SUM_W-1:0]   sum_nxt;
  logic signed [PROD_W-1:0]  prod_nxt;

  logic                      valid_a_r;
  logic                      sat_a_r;
  logic                      active_a_r;
  logic signed [ACC_W-1:0]   acc_a_r;
  logic signed [X_W-1:0]     x_a_r;
  logic signed [PROD_W-1:0]  prod_a_r;

  logic [PROD_W:0]           rnd_sum;
  logic [PROD_W-FRAC_W:0]    rnd_q;
  logic                      ovf;
  hpp_stage_t                out_nxt;
  hpp_stage_t                out_r;

  // First half: add the coefficient and multiply by x.
  always_comb begin
    sum_nxt  = SUM_W'(stage_in.acc) + SUM_W'(coef);
    prod_nxt = sum_nxt * stage_in.x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (en) begin
      valid_a_r <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_a_r    <= stage_in.sat;
      active_a_r <= active;
      acc_a_r    <= stage_in.acc;
      x_a_r      <= stage_in.x;
      prod_a_r   <= prod_nxt;
    end
  end

  // Second half: round to nearest (ties up) and saturate to 32 bits.
  always_comb begin
    rnd_sum = {prod_a_r[PROD_W-1], prod_a_r} + (PROD_W + 1)'(1 << (FRAC_W - 1));
    rnd_q   = rnd_sum[PROD_W:FRAC_W];
    ovf     = (rnd_q[PROD_W-FRAC_W:ACC_W-1] != {(PROD_W-FRAC_W-ACC_W+2){1'b0}}) &&
              (rnd_q[PROD_W-FRAC_W:ACC_W-1] != {(PROD_W-FRAC_W-ACC_W+2){1'b1}});
    out_nxt.valid = valid_a_r;
    out_nxt.x     = x_a_r;
    if (!active_a_r) begin
      out_nxt.acc = acc_a_r;
      out_nxt.sat = sat_a_r;
    end else if (ovf) begin
      out_nxt.acc = rnd_q[PROD_W-FRAC_W] ? SAT_LO : SAT_HI;
      out_nxt.sat = 1'b1;
    end else begin
      out_nxt.acc = $signed(rnd_q[ACC_W-1:0]);
      out_nxt.sat = sat_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (en) begin
      out_r.valid <= out_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.sat <= out_nxt.sat;
      out_r.acc <= out_nxt.acc;
      out_r.x   <= out_nxt.x;
    end
  end

  assign stage_out = out_r;

endmodule
